// ===== rtl/json_string_unescape_utf8_assert.svh =====
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// Same-cycle implication, checked on clk outside reset.
`define JSU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("json unescape assertion failed");

// Next-cycle implication, checked on clk outside reset.
`define JSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("json unescape assertion failed");

`endif

// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

    // Decoder modes, one-hot.
    typedef enum logic [6:0] {
        MODE_IDLE    = 7'b0000001,
        MODE_BODY    = 7'b0000010,
        MODE_ESC     = 7'b0000100,
        MODE_HEX_HI  = 7'b0001000,
        MODE_PAIR_BS = 7'b0010000,
        MODE_PAIR_U  = 7'b0100000,
        MODE_HEX_LO  = 7'b1000000
    } mode_t;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_EOT  = 1'b1;

    localparam logic [3:0] ST_RUN     = 4'd0;
    localparam logic [3:0] ST_CLOSED  = 4'd1;
    localparam logic [3:0] ST_NOQUOTE = 4'd2;
    localparam logic [3:0] ST_CONTROL = 4'd3;
    localparam logic [3:0] ST_BADESC  = 4'd4;
    localparam logic [3:0] ST_BADHEX  = 4'd5;
    localparam logic [3:0] ST_SURR    = 4'd6;
    localparam logic [3:0] ST_UNTERM  = 4'd7;
    localparam logic [3:0] ST_CUTESC  = 4'd8;
    localparam logic [3:0] ST_CUTUNI  = 4'd9;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CTRL_LIMIT   = 8'h20;

    // Upper six bits of high and low surrogate code units.
    localparam logic [5:0] SURR_HI_TAG = 6'b110110;
    localparam logic [5:0] SURR_LO_TAG = 6'b110111;
    // 0x10000 expressed in units of 1024.
    localparam logic [10:0] PAIR_BASE  = 11'd64;

    localparam logic [20:0] CP_MAX_1 = 21'h00007F;
    localparam logic [20:0] CP_MAX_2 = 21'h0007FF;
    localparam logic [20:0] CP_MAX_3 = 21'h00FFFF;

    // One input word's worth of results: up to four bytes, or a bare status.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            has_bytes;
        logic [3:0]      status;
    } group_t;

    // Returns {is_hex, nibble}.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic group_t utf8_group(input logic [20:0] cp);
        group_t g;
        g = '0;
        g.has_bytes = 1'b1;
        g.status    = ST_RUN;
        if (cp <= CP_MAX_1) begin
            g.bytes[0] = {1'b0, cp[6:0]};
            g.last_idx = 2'd0;
        end
        else if (cp <= CP_MAX_2) begin
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
            g.last_idx = 2'd1;
        end
        else if (cp <= CP_MAX_3) begin
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
            g.last_idx = 2'd2;
        end
        else begin
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
            g.last_idx = 2'd3;
        end
        return g;
    endfunction

endpackage

// ===== rtl/jsu_decode.sv =====
module jsu_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic            command,
    input  logic [7:0]      data_byte,
    output jsu_pkg::group_t grp
);
    import jsu_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [1:0]  digits_reg, digits_next;
    logic [11:0] acc_reg, acc_next;
    logic [9:0]  hs_reg, hs_next;
    logic        clear;
    logic        eot;
    logic [4:0]  hex;
    logic [15:0] acc_full;

    assign eot      = (command == CMD_EOT);
    assign hex      = hex_decode(data_byte);
    assign acc_full = {acc_reg, hex[3:0]};

    always_comb
    begin
        grp          = '0;
        grp.status   = ST_RUN;
        mode_next    = mode_reg;
        digits_next  = digits_reg;
        acc_next     = acc_reg;
        hs_next      = hs_reg;
        clear        = 1'b0;
        unique case (mode_reg)
            MODE_BODY:
            begin
                if (eot) begin
                    clear = 1'b1; grp.status = ST_UNTERM;
                end
                else if (data_byte == CH_QUOTE) begin
                    clear = 1'b1; grp.status = ST_CLOSED;
                end
                else if (data_byte < CTRL_LIMIT) begin
                    clear = 1'b1; grp.status = ST_CONTROL;
                end
                else if (data_byte == CH_BACKSLASH) begin
                    mode_next = MODE_ESC;
                end
                else begin
                    grp.has_bytes = 1'b1;
                    grp.bytes[0]  = data_byte;
                end
            end
            MODE_ESC:
            begin
                if (eot) begin
                    clear = 1'b1; grp.status = ST_CUTESC;
                end
                else begin
                    mode_next     = MODE_BODY;
                    grp.has_bytes = 1'b1;
                    case (data_byte) inside
                        CH_QUOTE, CH_BACKSLASH, CH_SLASH: grp.bytes[0] = data_byte;
                        8'h62: grp.bytes[0] = 8'h08;
                        8'h66: grp.bytes[0] = 8'h0C;
                        8'h6E: grp.bytes[0] = 8'h0A;
                        8'h72: grp.bytes[0] = 8'h0D;
                        8'h74: grp.bytes[0] = 8'h09;
                        CH_U:
                        begin
                            grp.has_bytes = 1'b0;
                            mode_next     = MODE_HEX_HI;
                            digits_next   = 2'd0;
                            acc_next      = '0;
                        end
                        default:
                        begin
                            grp.has_bytes = 1'b0;
                            clear         = 1'b1;
                            grp.status    = ST_BADESC;
                        end
                    endcase
                end
            end
            MODE_HEX_HI, MODE_HEX_LO:
            begin
                if (eot) begin
                    clear = 1'b1; grp.status = ST_CUTUNI;
                end
                else if (!hex[4]) begin
                    clear = 1'b1; grp.status = ST_BADHEX;
                end
                else if (digits_reg != 2'd3) begin
                    digits_next = digits_reg + 2'd1;
                    acc_next    = acc_full[11:0];
                end
                else if (mode_reg == MODE_HEX_HI) begin
                    if (acc_full[15:10] == SURR_HI_TAG) begin
                        hs_next     = acc_full[9:0];
                        acc_next    = '0;
                        digits_next = 2'd0;
                        mode_next   = MODE_PAIR_BS;
                    end
                    else if (acc_full[15:10] == SURR_LO_TAG) begin
                        clear = 1'b1; grp.status = ST_SURR;
                    end
                    else begin
                        grp = utf8_group({5'd0, acc_full});
                        mode_next   = MODE_BODY;
                        digits_next = 2'd0;
                        acc_next    = '0;
                        hs_next     = '0;
                    end
                end
                else begin
                    if (acc_full[15:10] != SURR_LO_TAG) begin
                        clear = 1'b1; grp.status = ST_SURR;
                    end
                    else begin
                        grp = utf8_group({({1'b0, hs_reg} + PAIR_BASE), acc_full[9:0]});
                        mode_next   = MODE_BODY;
                        digits_next = 2'd0;
                        acc_next    = '0;
                        hs_next     = '0;
                    end
                end
            end
            MODE_PAIR_BS:
            begin
                if (eot || data_byte != CH_BACKSLASH) begin
                    clear = 1'b1; grp.status = ST_SURR;
                end
                else begin
                    mode_next = MODE_PAIR_U;
                end
            end
            MODE_PAIR_U:
            begin
                if (eot || data_byte != CH_U) begin
                    clear = 1'b1; grp.status = ST_SURR;
                end
                else begin
                    mode_next   = MODE_HEX_LO;
                    digits_next = 2'd0;
                    acc_next    = '0;
                end
            end
            default:
            begin
                // Idle: wait for the opening quote.
                if (!eot && data_byte == CH_QUOTE) begin
                    mode_next   = MODE_BODY;
                    digits_next = 2'd0;
                    acc_next    = '0;
                    hs_next     = '0;
                end
                else begin
                    clear = 1'b1; grp.status = ST_NOQUOTE;
                end
            end
        endcase
        if (clear) begin
            mode_next   = MODE_IDLE;
            digits_next = 2'd0;
            acc_next    = '0;
            hs_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_IDLE;
            digits_reg <= 2'd0;
            acc_reg    <= '0;
            hs_reg     <= '0;
        end
        else if (fire) begin
            mode_reg   <= mode_next;
            digits_reg <= digits_next;
            acc_reg    <= acc_next;
            hs_reg     <= hs_next;
        end
    end

endmodule

// ===== rtl/jsu_emit.sv =====
module jsu_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  jsu_pkg::group_t grp,
    input  logic            result_stall,
    output logic            result_valid,
    output logic            can_load,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic [3:0]      status,
    output logic            last
);
    import jsu_pkg::*;

    group_t     grp_reg;
    logic [1:0] idx_reg;
    logic       full_reg;
    logic       take;
    logic       done;

    assign result_valid = full_reg;
    assign out_byte     = grp_reg.has_bytes ? grp_reg.bytes[idx_reg] : 8'd0;
    assign byte_valid   = grp_reg.has_bytes;
    assign status       = grp_reg.status;
    assign last         = (idx_reg == grp_reg.last_idx);
    assign take         = full_reg && !result_stall;
    assign done         = take && last;
    assign can_load     = !full_reg || done;

    always_ff @(posedge clk)
    begin
        if (load) begin
            grp_reg <= grp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            full_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (load) begin
            full_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (done) begin
            full_reg <= 1'b0;
        end
        else if (take) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// Output: the first result word of an input word appears the cycle after it is accepted.
// Throughput: one input word per cycle when it yields a single result word and the
// result channel does not stall; a code point of more than one UTF-8 byte stalls the input
// until the result register has drained it, one byte per cycle unless result_stall holds it.
// Reset: rst_n (async, active low) returns the decoder to idle, awaiting an opening quote,
// and empties the result register.
`include "json_string_unescape_utf8_assert.svh"

module json_string_unescape_utf8 (
    input  logic       clk,
    input  logic       rst_n,
    // Input channel: one JSON text byte or end-of-text command per word.
    input  logic       item_valid,
    output logic       item_stall,
    input  logic       command,
    input  logic [7:0] data_byte,
    // Result channel: one decoded byte or status per word.
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic [3:0] status,
    output logic       last
);
    import jsu_pkg::*;

    group_t grp;
    logic   can_load;
    logic   fire;

    // Accept a new word whenever the result register is empty or drains its
    // final word this cycle; the decoder state and the result group advance together.
    assign item_stall = !can_load;
    assign fire       = item_valid && can_load;

    // Decoder: mode, hex digit gathering and surrogate pairing; builds the
    // whole group of result words for the current input word in one pass.
    jsu_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .command   (command),
        .data_byte (data_byte),
        .grp       (grp)
    );

    // Result register: hold the group and present its words one per cycle unless result_stall is high.
    jsu_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire),
        .grp          (grp),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .can_load     (can_load),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .status       (status),
        .last         (last)
    );

    // A word without a byte is always the only, hence final, word of its group.
    `JSU_ASSERT_NOW(a_bare_status_is_last, result_valid && !byte_valid, last)
    // Terminal statuses never ride along with decoded bytes.
    `JSU_ASSERT_NOW(a_status_no_byte, result_valid && status != ST_RUN, !byte_valid)
    // An accepted word shows up at the output on the next cycle.
    `JSU_ASSERT_NEXT(a_accept_shows, fire, result_valid)
    // Taking a non-final word leaves the rest of the group pending.
    `JSU_ASSERT_NEXT(a_group_continues, result_valid && !result_stall && !last,
                     result_valid && byte_valid)

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_WORDS  = 400;
    localparam int DRAIN_CYCLES  = 10;

    // Surrogate code unit bounds.
    localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;

    // One word of JSON text as the sender presents it.
    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } text_word_t;

    // One word of decoder output.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [3:0] status;
        logic       last;
    } decoded_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    logic       command = CMD_DATA;
    logic [7:0] data_byte = 8'h00;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [3:0] status;
    logic       last;

    json_string_unescape_utf8 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .status       (status),
        .last         (last)
    );

    always #4 clk = ~clk;

    // Text words still to be sent, and decoder output still owed.
    text_word_t    text_queue[$];
    decoded_word_t expected_words[$];

    int total_words    = 1;
    int accepted_words = 0;
    int result_words   = 0;
    int decoded_bytes  = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    int status_hits[16];

    // Our own copy of the decoder state.
    mode_t       dec_mode;
    logic [1:0]  hex_count;
    logic [15:0] hex_acc;
    logic [9:0]  high_bits;

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    function automatic int hex_nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    task automatic owe_byte(input logic [7:0] b, input logic is_final);
        expected_words.insert(expected_words.size(),
                              '{out_byte: b, byte_valid: 1'b1, status: ST_RUN,
                                last: is_final});
    endtask

    task automatic owe_status(input logic [3:0] st);
        expected_words.insert(expected_words.size(),
                              '{out_byte: 8'h00, byte_valid: 1'b0, status: st,
                                last: 1'b1});
    endtask

    task automatic clear_decoder(input mode_t next_mode);
        dec_mode  = next_mode;
        hex_count = '0;
        hex_acc   = '0;
        high_bits = '0;
    endtask

    // End the string (or fail it) and go back to waiting for a quote.
    task automatic end_string(input logic [3:0] st);
        clear_decoder(MODE_IDLE);
        owe_status(st);
    endtask

    // Encode a code point as UTF-8, one word per byte.
    task automatic owe_code_point(input logic [20:0] cp);
        if (cp <= 21'h7F)
        begin
            owe_byte(cp[7:0], 1'b1);
        end
        else if (cp <= 21'h7FF)
        begin
            owe_byte(8'hC0 | 8'(cp >> 6), 1'b0);
            owe_byte(8'h80 | {2'b00, cp[5:0]}, 1'b1);
        end
        else if (cp <= 21'hFFFF)
        begin
            owe_byte(8'hE0 | 8'(cp >> 12), 1'b0);
            owe_byte(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b0);
            owe_byte(8'h80 | {2'b00, cp[5:0]}, 1'b1);
        end
        else
        begin
            owe_byte(8'hF0 | 8'((cp >> 18) & 21'h7), 1'b0);
            owe_byte(8'h80 | 8'((cp >> 12) & 21'h3F), 1'b0);
            owe_byte(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b0);
            owe_byte(8'h80 | {2'b00, cp[5:0]}, 1'b1);
        end
        clear_decoder(MODE_BODY);
    endtask

    // Advance the predicted decoder by one accepted text word.
    task automatic unescape_step(input logic cmd, input logic [7:0] c);
        logic        eot;
        int          nibble;
        logic [15:0] unit;
        logic [7:0]  plain;
        eot = (cmd == CMD_EOT);
        case (dec_mode)
            MODE_BODY:
            begin
                if (eot)
                    end_string(ST_UNTERM);
                else if (c == CH_QUOTE)
                    end_string(ST_CLOSED);
                else if (c < CTRL_LIMIT)
                    end_string(ST_CONTROL);
                else if (c == CH_BACKSLASH)
                begin
                    dec_mode = MODE_ESC;
                    owe_status(ST_RUN);
                end
                else
                    owe_byte(c, 1'b1);
            end
            MODE_ESC:
            begin
                if (eot)
                    end_string(ST_CUTESC);
                else if (c == CH_U)
                begin
                    dec_mode  = MODE_HEX_HI;
                    hex_count = '0;
                    hex_acc   = '0;
                    owe_status(ST_RUN);
                end
                else
                begin
                    plain = 8'h00;
                    case (c)
                        CH_QUOTE, CH_BACKSLASH, CH_SLASH: plain = c;
                        "b": plain = 8'h08;
                        "f": plain = 8'h0C;
                        "n": plain = 8'h0A;
                        "r": plain = 8'h0D;
                        "t": plain = 8'h09;
                        default: plain = 8'h00;
                    endcase
                    if (c == CH_QUOTE || c == CH_BACKSLASH || c == CH_SLASH || plain != 8'h00)
                    begin
                        dec_mode = MODE_BODY;
                        owe_byte(plain, 1'b1);
                    end
                    else
                        end_string(ST_BADESC);
                end
            end
            MODE_HEX_HI, MODE_HEX_LO:
            begin
                nibble = hex_nibble_of(c);
                if (eot)
                    end_string(ST_CUTUNI);
                else if (nibble < 0)
                    end_string(ST_BADHEX);
                else
                begin
                    hex_acc = {hex_acc[11:0], 4'(nibble)};
                    if (hex_count != 2'd3)
                    begin
                        hex_count = hex_count + 2'd1;
                        owe_status(ST_RUN);
                    end
                    else
                    begin
                        hex_count = '0;
                        unit = hex_acc;
                        if (dec_mode == MODE_HEX_HI)
                        begin
                            if (unit >= HIGH_SURR_FIRST && unit <= HIGH_SURR_LAST)
                            begin
                                // Hold the high half until its partner shows up.
                                high_bits = 10'(unit - HIGH_SURR_FIRST);
                                hex_acc   = '0;
                                dec_mode  = MODE_PAIR_BS;
                                owe_status(ST_RUN);
                            end
                            else if (unit >= LOW_SURR_FIRST && unit <= LOW_SURR_LAST)
                                end_string(ST_SURR);
                            else
                                owe_code_point({5'b0, unit});
                        end
                        else if (unit < LOW_SURR_FIRST || unit > LOW_SURR_LAST)
                            end_string(ST_SURR);
                        else
                            owe_code_point(21'h10000 + {1'b0, high_bits, 10'b0}
                                           + 21'(unit - LOW_SURR_FIRST));
                    end
                end
            end
            MODE_PAIR_BS:
            begin
                if (eot || c != CH_BACKSLASH)
                    end_string(ST_SURR);
                else
                begin
                    dec_mode = MODE_PAIR_U;
                    owe_status(ST_RUN);
                end
            end
            MODE_PAIR_U:
            begin
                if (eot || c != CH_U)
                    end_string(ST_SURR);
                else
                begin
                    dec_mode  = MODE_HEX_LO;
                    hex_count = '0;
                    hex_acc   = '0;
                    owe_status(ST_RUN);
                end
            end
            default:
            begin
                if (!eot && c == CH_QUOTE)
                begin
                    clear_decoder(MODE_BODY);
                    owe_status(ST_RUN);
                end
                else
                    end_string(ST_NOQUOTE);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    task automatic put_data(input logic [7:0] b);
        text_queue.insert(text_queue.size(), '{command: CMD_DATA, data_byte: b});
    endtask

    // The byte that rides along with end of text is random; the decoder must ignore it.
    task automatic put_eot();
        text_queue.insert(text_queue.size(),
                          '{command: CMD_EOT, data_byte: 8'($urandom_range(255))});
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + {4'b0, nib};
        return ($urandom_range(1) ? 8'h61 : 8'h41) + {4'b0, nib} - 8'd10;
    endfunction

    task automatic put_unit(input logic [15:0] v);
        put_data(CH_BACKSLASH);
        put_data(CH_U);
        put_data(hex_char(v[15:12]));
        put_data(hex_char(v[11:8]));
        put_data(hex_char(v[7:4]));
        put_data(hex_char(v[3:0]));
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(8'h20, 8'hFF));
        while (b == CH_QUOTE || b == CH_BACKSLASH);
        return b;
    endfunction

    function automatic logic is_escape_letter(input logic [7:0] b);
        return b == CH_QUOTE || b == CH_BACKSLASH || b == CH_SLASH || b == CH_U
            || b == "b" || b == "f" || b == "n" || b == "r" || b == "t";
    endfunction

    function automatic logic [7:0] escape_letter();
        case ($urandom_range(7))
            0: return CH_QUOTE;
            1: return CH_BACKSLASH;
            2: return CH_SLASH;
            3: return "b";
            4: return "f";
            5: return "n";
            6: return "r";
            default: return "t";
        endcase
    endfunction

    function automatic logic [7:0] random_byte_except(input logic [7:0] avoid);
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == avoid);
        return b;
    endfunction

    function automatic logic [7:0] bad_escape();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (is_escape_letter(b));
        return b;
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (hex_nibble_of(b) >= 0);
        return b;
    endfunction

    // A code unit outside the surrogate range, spread over the UTF-8 lengths.
    function automatic logic [15:0] bmp_unit();
        logic [15:0] u;
        case ($urandom_range(2))
            0: u = 16'($urandom_range(16'h007F));
            1: u = 16'($urandom_range(16'h0080, 16'h07FF));
            default:
                do
                    u = 16'($urandom_range(16'h0800, 16'hFFFF));
                while (u >= HIGH_SURR_FIRST && u <= LOW_SURR_LAST);
        endcase
        return u;
    endfunction

    function automatic logic [15:0] non_low_unit();
        logic [15:0] u;
        do
            u = 16'($urandom_range(16'hFFFF));
        while (u >= LOW_SURR_FIRST && u <= LOW_SURR_LAST);
        return u;
    endfunction

    // One string literal: random body, then mostly a closing quote, else a broken ending.
    task automatic put_string();
        int tokens;
        int kind;
        int ending;
        int digits;
        put_data(CH_QUOTE);
        tokens = $urandom_range(6);
        for (int i = 0; i < tokens; i++)
        begin
            kind = $urandom_range(9);
            if (kind < 4)
                put_data(plain_byte());
            else if (kind < 6)
            begin
                put_data(CH_BACKSLASH);
                put_data(escape_letter());
            end
            else if (kind < 9)
                put_unit(bmp_unit());
            else
            begin
                put_unit(HIGH_SURR_FIRST + 16'($urandom_range(10'h3FF)));
                put_unit(LOW_SURR_FIRST + 16'($urandom_range(10'h3FF)));
            end
        end
        ending = $urandom_range(19);
        case (ending)
            12: put_eot();
            13: put_data(8'($urandom_range(8'h1F)));
            14:
            begin
                put_data(CH_BACKSLASH);
                put_data(bad_escape());
            end
            15:
            begin
                put_data(CH_BACKSLASH);
                put_eot();
            end
            16, 17:
            begin
                // Cut or spoil a \u unit after zero to three digits.
                digits = $urandom_range(3);
                put_data(CH_BACKSLASH);
                put_data(CH_U);
                for (int j = 0; j < digits; j++)
                    put_data(hex_char(4'($urandom_range(15))));
                if (ending == 16)
                    put_eot();
                else
                    put_data(non_hex());
            end
            18: put_unit(LOW_SURR_FIRST + 16'($urandom_range(10'h3FF)));
            19:
            begin
                // Break the pair after a high surrogate in each possible spot.
                put_unit(HIGH_SURR_FIRST + 16'($urandom_range(10'h3FF)));
                case ($urandom_range(4))
                    0: put_data(random_byte_except(CH_BACKSLASH));
                    1: put_eot();
                    2:
                    begin
                        put_data(CH_BACKSLASH);
                        put_data(random_byte_except(CH_U));
                    end
                    3:
                    begin
                        put_data(CH_BACKSLASH);
                        put_eot();
                    end
                    default: put_unit(non_low_unit());
                endcase
            end
            default: put_data(CH_QUOTE);
        endcase
    endtask

    task automatic put_noise();
        int count;
        count = $urandom_range(1, 3);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3) == 0)
                put_eot();
            else
                put_data(8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------

    // Split the run in four by progress: no idling, sender gaps, receiver stalls, both light.
    function automatic int run_phase();
        return (accepted_words * 4) / total_words;
    endfunction

    function automatic logic sender_idles();
        case (run_phase())
            1: return $urandom_range(99) < 57;
            3: return $urandom_range(99) < 8;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_stalls();
        case (run_phase())
            2: return $urandom_range(99) < 57;
            3: return $urandom_range(99) < 8;
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: predict each accepted word, then present the next one or idle.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            command    <= CMD_DATA;
            data_byte  <= 8'h00;
            clear_decoder(MODE_IDLE);
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                unescape_step(command, data_byte);
                accepted_words++;
            end
            // Hold a stalled word as it is; only decide anew once it is gone.
            if (!item_valid || !item_stall)
            begin
                if (text_queue.size() != 0 && !sender_idles())
                begin
                    command    <= text_queue[0].command;
                    data_byte  <= text_queue[0].data_byte;
                    item_valid <= 1'b1;
                    void'(text_queue.pop_front());
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result word with the oldest one owed.
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result word %0d (cycle %0d): %s got 0x%0h, want 0x%0h",
                 result_words, cycle_count, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decoded_word_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word, status", int'(status), 0);
                else
                begin
                    want = expected_words.pop_front();
                    if (byte_valid !== want.byte_valid)
                        report_mismatch("byte_valid", int'(byte_valid),
                                        int'(want.byte_valid));
                    if (out_byte !== want.out_byte)
                        report_mismatch("out_byte", int'(out_byte), int'(want.out_byte));
                    if (status !== want.status)
                        report_mismatch("status", int'(status), int'(want.status));
                    if (last !== want.last)
                        report_mismatch("last", int'(last), int'(want.last));
                end
                if (byte_valid === 1'b1)
                    decoded_bytes++;
                if (!$isunknown(status))
                    status_hits[status]++;
                result_words++;
            end
            result_stall <= receiver_stalls();
        end
    end

    // Bound the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still owed",
                     cycle_count, expected_words.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------

    initial
    begin
        string seen;
        seen = "";

        // Idle: a stray byte, then end of text with no string open.
        put_data("A");
        put_eot();
        // Body extremes, then a control byte.
        put_data(CH_QUOTE);
        put_data(8'h20);
        put_data(8'hFF);
        put_data(8'h1F);
        // Highest code point from a pair, then end of text right after a backslash.
        put_data(CH_QUOTE);
        put_unit(HIGH_SURR_LAST);
        put_unit(LOW_SURR_LAST);
        put_data(CH_BACKSLASH);
        put_eot();
        // Top of the basic plane, then a clean close.
        put_data(CH_QUOTE);
        put_unit(16'hFFFF);
        put_data(CH_QUOTE);

        // Mostly well-formed strings with random content, some noise between them.
        while (text_queue.size() < RANDOM_WORDS + 30)
        begin
            if ($urandom_range(99) < 85)
                put_string();
            else
                put_noise();
        end
        total_words = text_queue.size();

        repeat (9) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (text_queue.size() != 0 || item_valid)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        // Let any stray word surface.
        repeat (DRAIN_CYCLES) @(posedge clk);

        for (int s = 0; s < 16; s++)
            if (status_hits[s] != 0)
                seen = {seen, $sformatf(" %0d(x%0d)", s, status_hits[s])};
        $display("sent %0d text words, checked %0d result words carrying %0d decoded bytes",
                 accepted_words, result_words, decoded_bytes);
        $display("status codes observed:%s", seen);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_emit.sv
rtl/json_string_unescape_utf8.sv
tb/testbench.sv
